// File: hw/rtl/qnns_pkg.sv
// shared types, constants and codes of the quadtree node nibble store
`timescale 1ns / 1ps
package qnns_pkg;

  localparam int MAX_NODES = 1024;
  localparam int NODE_BITS = 4;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = IDX_W + 1;

  localparam logic [CNT_W:0] MAX_NODES_C = (CNT_W + 1)'(MAX_NODES);

  typedef enum logic [2:0] {
    KIND_QUERY  = 3'd0,
    KIND_READ   = 3'd1,
    KIND_WRITE  = 3'd2,
    KIND_SET    = 3'd3,
    KIND_GAP    = 3'd4,
    KIND_REMOVE = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ORDER    = 2'd1,
    ST_WHOLE    = 2'd2,
    ST_CAPACITY = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SETWR,
    S_GMOVE,
    S_GZERO,
    S_RMOVE,
    S_RZERO,
    S_FRD,
    S_FOUT
  } state_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [IDX_W-1:0] node_idx;
    logic [IDX_W-1:0] range_end;
    logic [CNT_W-1:0] gap_nodes;
    logic [1:0]       child;
  } in_t;

  typedef struct packed {
    logic [NODE_BITS-1:0] node_bits;
    logic                 child_present;
    logic [2:0]           child_count;
    logic [CNT_W-1:0]     node_total;
    logic [1:0]           status;
  } out_t;

  typedef struct packed {
    logic                 we;
    logic [IDX_W-1:0]     waddr;
    logic [NODE_BITS-1:0] wdata;
    logic                 re;
    logic [IDX_W-1:0]     raddr;
  } mem_req_t;

  // one-hot node for a child code, child 0 in the top bit
  function automatic logic [NODE_BITS-1:0] one_hot(input logic [1:0] c);
    one_hot = NODE_BITS'(1) << (2'd3 - c);
  endfunction

endpackage

// File: hw/rtl/qnns_store.sv
// node memory: one write port, one registered read port
`timescale 1ns / 1ps
module qnns_store
  import qnns_pkg::*;
(
  input  logic                 clk,
  input  mem_req_t             req,
  output logic [NODE_BITS-1:0] rdata
);

  logic [NODE_BITS-1:0] mem [MAX_NODES];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// File: hw/rtl/quadtree_node_nibble_store.sv
// top level: operation sequencer around the node memory
// query, read, write: the node is read in S_FRD and the result registered in S_FOUT; set reads first, writes in S_SETWR
// gap: S_GMOVE moves nodes up, then S_GZERO clears the gap; remove: S_RMOVE then S_RZERO, or S_RZERO if none move
// one operation at a time, in_ready returns with out_valid; a held result stalls the next one
// reset: synchronous, then a clearing pass that zeroes all 1024 nodes with in_ready low
`timescale 1ns / 1ps
module quadtree_node_nibble_store
  import qnns_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  state_t           state_r, state_nxt;
  in_t              op_r, op_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0] src_r, src_nxt;
  logic [CNT_W-1:0] zp_r, zp_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [1:0]       stat_r, stat_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] pend_addr_r, pend_addr_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;
  mem_req_t         req;
  logic [NODE_BITS-1:0] rd_q;

  qnns_store u_store (.clk(clk), .req(req), .rdata(rd_q));

  // decode of an incoming operation
  logic             accept;
  logic [CNT_W-1:0] idx_in, rng_in, rm_len;
  logic [CNT_W:0]   gap_sum;
  logic             wr_over, set_ok, gap_over, gap_noop, rm_order, rm_bad;

  assign accept   = in_valid && in_ready;
  assign idx_in   = {1'b0, in_data.node_idx};
  assign rng_in   = {1'b0, in_data.range_end};
  assign gap_sum  = {1'b0, total_r} + {1'b0, in_data.gap_nodes};
  assign wr_over  = {1'b0, idx_in} >= MAX_NODES_C;
  assign set_ok   = idx_in < total_r;
  assign gap_over = gap_sum > MAX_NODES_C;
  assign gap_noop = (in_data.gap_nodes == '0) || (idx_in + CNT_W'(1) >= total_r);
  assign rm_order = in_data.range_end < in_data.node_idx;
  assign rm_len   = rng_in - idx_in + CNT_W'(1);
  assign rm_bad   = (rm_len >= total_r) || (rng_in >= total_r);

  // loop bounds of the running operation
  logic [CNT_W-1:0] op_idx1, gap_last, rm_base;
  logic             out_free;
  assign op_idx1  = {1'b0, op_r.node_idx} + CNT_W'(1);
  assign gap_last = {1'b0, op_r.node_idx} + op_r.gap_nodes;
  assign rm_base  = total_r - len_r;
  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (zp_r == CNT_W'(MAX_NODES - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_FRD;
          case (in_data.kind)
            KIND_SET: if (set_ok) state_nxt = S_SETWR;
            KIND_GAP: if (!gap_over && !gap_noop) state_nxt = S_GMOVE;
            KIND_REMOVE: begin
              if (!rm_order && !rm_bad) begin
                state_nxt = (rng_in + CNT_W'(1) < total_r) ? S_RMOVE : S_RZERO;
              end
            end
            default: state_nxt = S_FRD;
          endcase
        end
      end
      S_SETWR: state_nxt = S_FRD;
      S_GMOVE: if (!(src_r > op_idx1) && !pend_r) state_nxt = S_GZERO;
      S_GZERO: if (zp_r == gap_last) state_nxt = S_FRD;
      S_RMOVE: if (!(src_r < total_r) && !pend_r) state_nxt = S_RZERO;
      S_RZERO: if (zp_r == total_r - CNT_W'(1)) state_nxt = S_FRD;
      S_FRD:   state_nxt = S_FOUT;
      S_FOUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory requests
  logic [NODE_BITS-1:0] res_bits;
  always_comb begin
    op_nxt        = op_r;
    total_nxt     = total_r;
    src_nxt       = src_r;
    zp_nxt        = zp_r;
    len_nxt       = len_r;
    stat_nxt      = stat_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    req           = '0;
    res_bits      = ({1'b0, op_r.node_idx} < total_r) ? rd_q : '0;

    // a pending move write lands in the cycle after its read
    if (pend_r) begin
      req.we    = 1'b1;
      req.waddr = pend_addr_r;
      req.wdata = rd_q;
    end

    case (state_r)
      S_CLEAR: begin
        req.we    = 1'b1;
        req.waddr = zp_r[IDX_W-1:0];
        req.wdata = '0;
        zp_nxt    = zp_r + CNT_W'(1);
      end
      S_IDLE: begin
        if (accept) begin
          op_nxt   = in_data;
          stat_nxt = ST_OK;
          case (in_data.kind)
            KIND_WRITE: begin
              if (wr_over) begin
                stat_nxt = ST_CAPACITY;
              end else begin
                req.we    = 1'b1;
                req.waddr = in_data.node_idx;
                req.wdata = one_hot(in_data.child);
                if (idx_in + CNT_W'(1) > total_r) total_nxt = idx_in + CNT_W'(1);
              end
            end
            KIND_SET: begin
              req.re    = 1'b1;
              req.raddr = in_data.node_idx;
            end
            KIND_GAP: begin
              if (gap_over) stat_nxt = ST_CAPACITY;
              src_nxt = total_r;
              len_nxt = in_data.gap_nodes;
              zp_nxt  = idx_in + CNT_W'(1);
            end
            KIND_REMOVE: begin
              if (rm_order)    stat_nxt = ST_ORDER;
              else if (rm_bad) stat_nxt = ST_WHOLE;
              src_nxt = rng_in + CNT_W'(1);
              len_nxt = rm_len;
              zp_nxt  = total_r - rm_len;
            end
            default: stat_nxt = ST_OK;
          endcase
        end
      end
      S_SETWR: begin
        req.we    = 1'b1;
        req.waddr = op_r.node_idx;
        req.wdata = rd_q | one_hot(op_r.child);
      end
      S_GMOVE: begin
        // walk down from the top, node i-1 goes to i-1+n
        if (src_r > op_idx1) begin
          req.re        = 1'b1;
          req.raddr     = IDX_W'(src_r - CNT_W'(1));
          pend_nxt      = 1'b1;
          pend_addr_nxt = IDX_W'(src_r - CNT_W'(1) + len_r);
          src_nxt       = src_r - CNT_W'(1);
        end
      end
      S_GZERO: begin
        req.we    = 1'b1;
        req.waddr = zp_r[IDX_W-1:0];
        req.wdata = '0;
        zp_nxt    = zp_r + CNT_W'(1);
        if (zp_r == gap_last) total_nxt = total_r + len_r;
      end
      S_RMOVE: begin
        // walk up past the range, node i goes to i-len
        if (src_r < total_r) begin
          req.re        = 1'b1;
          req.raddr     = src_r[IDX_W-1:0];
          pend_nxt      = 1'b1;
          pend_addr_nxt = IDX_W'(src_r - len_r);
          src_nxt       = src_r + CNT_W'(1);
        end else begin
          zp_nxt = rm_base;
        end
      end
      S_RZERO: begin
        req.we    = 1'b1;
        req.waddr = zp_r[IDX_W-1:0];
        req.wdata = '0;
        zp_nxt    = zp_r + CNT_W'(1);
        if (zp_r == total_r - CNT_W'(1)) total_nxt = rm_base;
      end
      S_FRD: begin
        req.re    = 1'b1;
        req.raddr = op_r.node_idx;
      end
      S_FOUT: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_nxt.node_bits     = res_bits;
          out_nxt.child_present = res_bits[2'd3 - op_r.child];
          out_nxt.child_count   = 3'(res_bits[0]) + 3'(res_bits[1])
                                + 3'(res_bits[2]) + 3'(res_bits[3]);
          out_nxt.node_total    = total_r;
          out_nxt.status        = stat_r;
        end
      end
      default: pend_nxt = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      total_r     <= '0;
      zp_r        <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      zp_r        <= zp_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    src_r       <= src_nxt;
    len_r       <= len_nxt;
    stat_r      <= stat_nxt;
    pend_addr_r <= pend_addr_nxt;
    out_r       <= out_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, total_r} <= MAX_NODES_C)
    else $error("node count above capacity");

  a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_r)
    else $error("move write left pending while idle");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("accepted transfer did not start an operation");

endmodule

// File: verif/qnns_checker.sv
// checker: watches both channels, predicts node store results and compares
`timescale 1ns / 1ps
module qnns_checker
  import qnns_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_t out_data,
  output int   fail_count,
  output int   pending,
  output int   result_count
);

  // shadow copy of the node store and count
  logic [NODE_BITS-1:0] shadow_nodes [MAX_NODES];
  int unsigned          shadow_total;
  out_t                 expected_q [$];

  initial begin
    fail_count   = 0;
    result_count = 0;
    shadow_total = 0;
    for (int i = 0; i < MAX_NODES; i++) shadow_nodes[i] = '0;
  end

  assign pending = expected_q.size();

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // apply one operation to the shadow state and compute its result
  function automatic out_t apply_op(input in_t op);
    out_t        r;
    int unsigned idx, last, gap, len;
    logic [1:0]  st;
    logic [3:0]  bits;
    idx  = op.node_idx;
    last = op.range_end;
    gap  = op.gap_nodes;
    st   = ST_OK;
    bits = '0;
    case (op.kind)
      KIND_WRITE: begin
        shadow_nodes[idx] = 4'(1) << (3 - op.child);
        if (idx + 1 > shadow_total) shadow_total = idx + 1;
      end
      KIND_SET: begin
        if (idx < shadow_total) shadow_nodes[idx] |= 4'(1) << (3 - op.child);
      end
      KIND_GAP: begin
        if (shadow_total + gap > MAX_NODES) st = ST_CAPACITY;
        else if (gap != 0 && idx + 1 < shadow_total) begin
          for (int i = shadow_total; i > idx + 1; i--)
            shadow_nodes[i - 1 + gap] = shadow_nodes[i - 1];
          for (int i = idx + 1; i < idx + 1 + gap; i++) shadow_nodes[i] = '0;
          shadow_total += gap;
        end
      end
      KIND_REMOVE: begin
        if (idx > last) st = ST_ORDER;
        else begin
          len = last - idx + 1;
          if (len >= shadow_total || last >= shadow_total) st = ST_WHOLE;
          else begin
            for (int i = last + 1; i < shadow_total; i++)
              shadow_nodes[i - len] = shadow_nodes[i];
            for (int i = shadow_total - len; i < shadow_total; i++) shadow_nodes[i] = '0;
            shadow_total -= len;
          end
        end
      end
      default: ;
    endcase
    if (idx < shadow_total) bits = shadow_nodes[idx];
    r.node_bits     = bits;
    r.child_present = bits[3 - op.child];
    r.child_count   = 3'(bits[0]) + 3'(bits[1]) + 3'(bits[2]) + 3'(bits[3]);
    r.node_total    = CNT_W'(shadow_total);
    r.status        = st;
    return r;
  endfunction

  // predict on input transfer, compare on result transfer
  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      if (in_valid && in_ready) expected_q.push_back(apply_op(in_data));
      if (out_valid && out_ready) begin
        result_count++;
        if (expected_q.size() == 0) begin
          $display("mismatch at %0t: result with nothing expected", $realtime);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_data.node_bits != want.node_bits)
            report_mismatch("node_bits", out_data.node_bits, want.node_bits);
          if (out_data.child_present != want.child_present)
            report_mismatch("child_present", out_data.child_present, want.child_present);
          if (out_data.child_count != want.child_count)
            report_mismatch("child_count", out_data.child_count, want.child_count);
          if (out_data.node_total != want.node_total)
            report_mismatch("node_total", out_data.node_total, want.node_total);
          if (out_data.status != want.status)
            report_mismatch("status", out_data.status, want.status);
        end
      end
    end
  end

endmodule

// File: verif/testbench.sv
// testbench top: stimulus for the node store and the final verdict
`timescale 1ns / 1ps
module testbench;
  import qnns_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  int   fail_count;
  int   pending;
  int   result_count;
  int   items_sent;

  quadtree_node_nibble_store u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  qnns_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending(pending), .result_count(result_count)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // send one operation and hold it until the transfer
  task automatic send_op(input logic [2:0] kind, input int idx, input int last,
                         input int gap, input int child);
    int gap_wait;
    gap_wait = $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0) gap_wait = 0;
    if (gap_wait > 0) begin
      in_valid <= 1'b0;
      repeat (gap_wait) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{kind: kind, node_idx: IDX_W'(idx), range_end: IDX_W'(last),
                  gap_nodes: CNT_W'(gap), child: 2'(child)};
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // random operation weighted toward in-range indexes and small moves
  task automatic send_random(input int near);
    int          sel, k, idx, last, gap;
    logic [2:0]  kind;
    sel = $urandom_range(0, 99);
    if (sel < 30) kind = KIND_WRITE;
    else if (sel < 45) kind = KIND_SET;
    else if (sel < 60) kind = KIND_QUERY;
    else if (sel < 70) kind = KIND_READ;
    else if (sel < 82) kind = KIND_GAP;
    else if (sel < 96) kind = KIND_REMOVE;
    else kind = 3'($urandom_range(6, 7));
    k = (near < 2) ? 2 : near;
    idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, k + 2);
    if (idx > 1023) idx = 1023;
    last = idx + $urandom_range(0, 6);
    if ($urandom_range(0, 7) == 0) last = $urandom_range(0, 1023);
    if (last > 1023) last = 1023;
    gap = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1024) : $urandom_range(0, 8);
    send_op(kind, idx, last, gap, $urandom_range(0, 3));
  endtask

  // result side: random stall before each transfer, with calm stretches
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // run limit
  initial begin
    #400ms;
    $display("quadtree_node_nibble_store test failed");
    $finish;
  end

  initial begin
    int wait_cycles;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    items_sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty store, extremes, every kind, error paths
    send_op(KIND_QUERY, 0, 0, 0, 0);
    send_op(KIND_REMOVE, 0, 0, 0, 0);
    send_op(KIND_GAP, 0, 0, 5, 0);
    send_op(KIND_WRITE, 0, 0, 0, 0);
    send_op(KIND_WRITE, 1, 0, 0, 3);
    send_op(KIND_WRITE, 3, 0, 0, 1);
    send_op(KIND_SET, 0, 0, 0, 3);
    send_op(KIND_SET, 1, 0, 0, 0);
    send_op(KIND_SET, 900, 0, 0, 2);
    send_op(KIND_READ, 0, 0, 0, 1);
    send_op(KIND_READ, 2, 0, 0, 2);
    send_op(KIND_GAP, 0, 0, 2, 0);
    send_op(KIND_GAP, 5, 0, 3, 0);
    send_op(KIND_GAP, 1, 0, 0, 0);
    send_op(KIND_GAP, 0, 0, 1024, 0);
    send_op(KIND_REMOVE, 4, 2, 0, 0);
    send_op(KIND_REMOVE, 0, 5, 0, 0);
    send_op(KIND_REMOVE, 1, 2, 0, 0);
    send_op(KIND_REMOVE, 0, 1023, 0, 0);
    send_op(3'd6, 1023, 1023, 2047, 3);
    send_op(3'd7, 0, 0, 0, 0);
    send_op(KIND_WRITE, 1023, 1023, 0, 2);
    send_op(KIND_QUERY, 1023, 0, 0, 2);
    send_op(KIND_REMOVE, 1, 1022, 0, 0);
    send_op(KIND_GAP, 0, 1023, 1023, 1);

    // random part: mostly well-formed ops at indexes near items_sent modulo 64
    repeat (1000) send_random(items_sent % 64);
    in_valid <= 1'b0;

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (3000) @(posedge clk);
    $display("sent %0d operations, checked %0d results", items_sent, result_count);
    if (fail_count == 0 && pending == 0)
      $display("quadtree_node_nibble_store test passed");
    else
      $display("quadtree_node_nibble_store test failed");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/qnns_pkg.sv
hw/rtl/qnns_store.sv
hw/rtl/quadtree_node_nibble_store.sv
verif/qnns_checker.sv
verif/testbench.sv
